// File: hw/rtl/rgrc_pkg.sv
// ----------------------------------------------------------------------------
// rgrc_pkg
// shared constants and types for the rtt gradient rate controller
// ----------------------------------------------------------------------------
`default_nettype none

package rgrc_pkg;

    localparam int unsigned RttW   = 32;
    localparam int unsigned RateW  = 32;
    localparam int unsigned AvgW   = 49;
    localparam int unsigned QW     = 17;
    localparam int unsigned CntW   = 3;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [QW-1:0] QOne = 17'd65536;
    localparam logic [CntW-1:0] HyperCount   = 3'd5;
    localparam logic [CntW-1:0] RestartCount = 3'd1;

    typedef enum logic [2:0] {
        REG_NONE  = 3'd0,
        REG_LOW   = 3'd1,
        REG_HIGH  = 3'd2,
        REG_ADD   = 3'd3,
        REG_HYPER = 3'd4,
        REG_GDEC  = 3'd5
    } t_region;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INITIAL_RATE = 3'd0,
        CFG_MIN_RTT      = 3'd1,
        CFG_T_LOW        = 3'd2,
        CFG_T_HIGH       = 3'd3,
        CFG_RATE_STEP    = 3'd4,
        CFG_EWMA_WEIGHT  = 3'd5,
        CFG_DECREASE     = 3'd6
    } t_cfg_idx;

    // request to the serial divider
    typedef struct packed {
        logic            start;
        logic [63:0]     dividend;
        logic [31:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [63:0]     quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/rgrc_divider.sv
// ----------------------------------------------------------------------------
// rgrc_divider
// restoring divider, one quotient bit per cycle, 64 by 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module rgrc_divider
    import rgrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic        r_done;

    logic [32:0] w_shift;
    logic [33:0] w_sub;

    assign w_shift = {r_rem, r_quo[63]};
    assign w_sub   = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so 32 bits hold it
                if (!w_sub[33]) begin
                    r_rem <= w_sub[31:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_shift[31:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 7'd0)) else $error("divider count ran out while busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider busy after done");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rgrc_serial_mul.sv
// ----------------------------------------------------------------------------
// rgrc_serial_mul
// shift and add multiplier, 4-bit digit of the multiplier per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rgrc_serial_mul
    import rgrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [35:0] i_b,
    output logic             o_done,
    output logic [99:0]      o_p
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [35:0] r_b;
    logic [99:0] r_a;
    logic [99:0] r_p;
    logic [99:0] w_part;

    // one digit as four shifted copies of the multiplicand
    assign w_part = (r_b[0] ? r_a : 100'd0)
                  + (r_b[1] ? {r_a[98:0], 1'b0} : 100'd0)
                  + (r_b[2] ? {r_a[97:0], 2'b00} : 100'd0)
                  + (r_b[3] ? {r_a[96:0], 3'b000} : 100'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd9;
                r_a    <= {36'd0, i_a};
                r_b    <= i_b;
                r_p    <= '0;
            end else if (r_busy) begin
                r_p   <= r_p + w_part;
                r_a   <= {r_a[95:0], 4'd0};
                r_b   <= {4'd0, r_b[35:4]};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("multiplier done without work");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 4'd0)) else $error("multiplier count ran out");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("multiplier busy after done");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rtt_gradient_rate_controller_unit.sv
// ----------------------------------------------------------------------------
// rtt_gradient_rate_controller_unit
// rtt gradient rate controller, one rate update per ack
// ----------------------------------------------------------------------------
// Each item on the slave side is one ack rtt in ns; exactly one result item
// (rate, region, clamped) comes out for it. The moving average runs three
// passes through a 4-bit-digit serial multiplier; the gradient and
// high-threshold decrease add a 64-bit restoring divider and one or two more
// multiplier passes. One item is in work at a time; its result moves to the
// output register once that is free, and the next item is taken after that.
`default_nettype none

module rtt_gradient_rate_controller_unit
    import rgrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // rtt_ns
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // rate[31:0], region[34:32], clamped[35]
);

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_AVG, S_DEC, S_HDIV, S_HMUL,
        S_GDIV, S_GMUL1, S_GMUL2, S_OUT
    } t_state;

    t_state r_state;

    logic [31:0] r_min_rtt, r_t_low, r_t_high, r_rate_step;
    logic [16:0] r_ewma_weight, r_decrease;

    logic [31:0] r_prev_rtt, r_rtt, r_last;
    logic signed [48:0] r_avg;
    logic [31:0] r_rate;
    logic [2:0]  r_cnt;

    logic signed [66:0] r_acc;
    logic [39:0] r_res;
    logic [39:0] r_out;
    logic        r_out_valid;

    logic [16:0] w_a, w_beta, w_w;
    logic [31:0] w_mr;
    logic [33:0] w_diff;  // signed
    logic [33:0] w_diff_abs;

    logic        r_mstart;
    logic [63:0] r_ma;
    logic [35:0] r_mb;
    logic        w_mdone;
    logic [99:0] w_mp;

    t_div_req    r_dreq;
    t_div_rsp    w_drsp;

    assign w_a    = (r_ewma_weight > QOne) ? QOne : r_ewma_weight;
    assign w_beta = (r_decrease > QOne) ? QOne : r_decrease;
    assign w_w    = QOne - w_a;
    assign w_mr   = (r_min_rtt == 32'd0) ? 32'd1 : r_min_rtt;
    assign w_diff = {2'b00, r_rtt} - {2'b00, r_last};
    assign w_diff_abs = w_diff[33] ? (34'd0 - w_diff) : w_diff;

    rgrc_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    rgrc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (w_drsp)
    );

    // hi = floor(avg/65536) in sign-magnitude for the multiplier
    logic signed [32:0] w_hi;
    logic [32:0] w_hi_abs;
    logic [15:0] w_lo;
    assign w_hi     = 33'(r_avg >>> 16);
    assign w_lo     = r_avg[15:0];
    assign w_hi_abs = w_hi[32] ? (33'd0 - w_hi) : w_hi;

    logic signed [66:0] w_sat_hi, w_sat_lo;
    assign w_sat_hi = 67'sh0FFFFFFFFFFFF;
    assign w_sat_lo = -67'sh1000000000000;

    logic [32:0] w_add1, w_add5;
    logic [34:0] w_step5;
    logic [35:0] w_sum5;
    assign w_add1  = {1'b0, r_rate} + {1'b0, r_rate_step};
    assign w_step5 = {3'b000, r_rate_step} + {1'b0, r_rate_step, 2'b00};
    assign w_sum5  = {4'd0, r_rate} + {1'b0, w_step5};
    assign w_add5  = w_sum5[35:32] != 4'd0 ? 33'h1_0000_0000 : w_sum5[32:0];

    logic        w_busy;
    assign w_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_min_rtt      <= 32'd10000;
            r_t_low        <= 32'd50000;
            r_t_high       <= 32'd500000;
            r_rate_step    <= 32'd10000;
            r_ewma_weight  <= 17'd57344;
            r_decrease     <= 17'd52429;
            r_prev_rtt     <= '0;
            r_avg          <= '0;
            r_rate         <= 32'd100000000;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_mstart       <= 1'b0;
            r_dreq.start   <= 1'b0;
        end else begin
            r_mstart     <= 1'b0;
            r_dreq.start <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_INITIAL_RATE: r_rate <= i_cfg_data;
                    CFG_MIN_RTT:     r_min_rtt     <= i_cfg_data;
                    CFG_T_LOW:       r_t_low       <= i_cfg_data;
                    CFG_T_HIGH:      r_t_high      <= i_cfg_data;
                    CFG_RATE_STEP:   r_rate_step   <= i_cfg_data;
                    CFG_EWMA_WEIGHT: r_ewma_weight <= i_cfg_data[16:0];
                    CFG_DECREASE:    r_decrease    <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_rtt      <= s_axis_tdata;
                        r_last     <= r_prev_rtt;
                        r_prev_rtt <= s_axis_tdata;
                        r_state    <= S_M1;
                    end
                end
                S_M1: begin
                    // |hi| * w
                    r_ma     <= {31'd0, w_hi_abs};
                    r_mb     <= {19'd0, w_w};
                    r_mstart <= 1'b1;
                    r_state  <= S_M2;
                end
                S_M2: begin
                    if (w_mdone) begin
                        r_acc <= w_hi[32] ? -$signed({1'b0, w_mp[65:0]})
                                          : $signed({1'b0, w_mp[65:0]});
                        r_ma     <= {48'd0, w_lo};
                        r_mb     <= {19'd0, w_w};
                        r_mstart <= 1'b1;
                        r_state  <= S_M3;
                    end
                end
                S_M3: begin
                    if (w_mdone) begin
                        r_acc    <= r_acc + $signed({35'd0, w_mp[47:16]});
                        r_ma     <= {30'd0, w_diff_abs};
                        r_mb     <= {19'd0, w_a};
                        r_mstart <= 1'b1;
                        r_state  <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (w_mdone) begin
                        logic signed [66:0] v_nv;
                        v_nv = w_diff[33] ? r_acc - $signed({1'b0, w_mp[65:0]})
                                          : r_acc + $signed({1'b0, w_mp[65:0]});
                        if (v_nv > w_sat_hi) v_nv = w_sat_hi;
                        if (v_nv < w_sat_lo) v_nv = w_sat_lo;
                        r_avg   <= v_nv[48:0];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= S_OUT;
                    if (r_last == 32'd0) begin
                        r_res <= {4'd0, 1'b0, REG_NONE, r_rate};
                    end else if (r_rtt < r_t_low) begin
                        r_rate <= w_add1[32] ? 32'hFFFF_FFFF : w_add1[31:0];
                        r_res  <= {4'd0, w_add1[32], REG_LOW,
                                   w_add1[32] ? 32'hFFFF_FFFF : w_add1[31:0]};
                    end else if (r_rtt > r_t_high) begin
                        r_ma     <= {47'd0, w_beta};
                        r_mb     <= {4'd0, r_rtt - r_t_high};
                        r_mstart <= 1'b1;
                        r_state  <= S_HDIV;
                    end else if (r_avg <= 0) begin
                        if (r_cnt >= HyperCount) begin
                            r_rate <= w_add5[32] ? 32'hFFFF_FFFF : w_add5[31:0];
                            r_res  <= {4'd0, w_add5[32], REG_HYPER,
                                       w_add5[32] ? 32'hFFFF_FFFF : w_add5[31:0]};
                        end else begin
                            r_cnt  <= r_cnt + 3'd1;
                            r_rate <= w_add1[32] ? 32'hFFFF_FFFF : w_add1[31:0];
                            r_res  <= {4'd0, w_add1[32], REG_ADD,
                                       w_add1[32] ? 32'hFFFF_FFFF : w_add1[31:0]};
                        end
                    end else begin
                        r_cnt           <= RestartCount;
                        r_dreq.dividend <= {15'd0, r_avg};
                        r_dreq.divisor  <= w_mr;
                        r_dreq.start    <= 1'b1;
                        r_state         <= S_GDIV;
                    end
                end
                S_HDIV: begin
                    // beta*(rtt-t_high), then divide by rtt
                    if (w_mdone) begin
                        r_dreq.dividend <= w_mp[63:0];
                        r_dreq.divisor  <= r_rtt;
                        r_dreq.start    <= 1'b1;
                        r_state         <= S_HMUL;
                    end
                end
                S_HMUL: begin
                    if (w_drsp.done) begin
                        r_ma     <= {32'd0, r_rate};
                        r_mb     <= w_drsp.quotient[35:0];
                        r_mstart <= 1'b1;
                        r_state  <= S_GMUL2;
                        r_res[34:32] <= REG_HIGH;
                    end
                end
                S_GDIV: begin
                    if (w_drsp.done) begin
                        r_ma     <= (w_drsp.quotient > 64'h1_0000_0000) ?
                                    64'h1_0000_0000 : w_drsp.quotient;
                        r_mb     <= {19'd0, w_beta};
                        r_mstart <= 1'b1;
                        r_state  <= S_GMUL1;
                    end
                end
                S_GMUL1: begin
                    if (w_mdone) begin
                        if (w_mp[65:16] > 50'd65536) begin
                            r_rate  <= '0;
                            r_res   <= {4'd0, 1'b1, REG_GDEC, 32'd0};
                            r_state <= S_OUT;
                        end else begin
                            r_ma     <= {32'd0, r_rate};
                            r_mb     <= {19'd0, w_mp[32:16]};
                            r_mstart <= 1'b1;
                            r_res[34:32] <= REG_GDEC;
                            r_state  <= S_GMUL2;
                        end
                    end
                end
                S_GMUL2: begin
                    if (w_mdone) begin
                        r_rate  <= r_rate - w_mp[47:16];
                        r_res   <= {4'd0, 1'b0, r_res[34:32], r_rate - w_mp[47:16]};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait for the output register to drain
                    if (!r_out_valid) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = !w_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= HyperCount) else $error("increase count above limit");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> r_out_valid)
        else $error("result lost");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accepted while busy");
`endif

endmodule

`default_nettype wire

// File: dv/rgrc_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgrc_scoreboard
// Watches the config port and both stream sides of the rate controller. It
// keeps its own copy of the controller state, predicts the result for every
// accepted rtt item, and compares each returned item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rgrc_scoreboard
    import rgrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending
);

    typedef struct {
        logic [31:0] rate;
        t_region     region;
        logic        clamped;
    } t_rate_update;

    localparam longint AvgMax = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint AvgMin = -AvgMax - 1;

    // controller settings
    longint unsigned base_rtt, thr_low, thr_high, add_step, alpha_q, beta_q;
    // controller state
    logic [31:0] last_rtt;
    longint      diff_avg;
    logic [31:0] cur_rate;
    int unsigned inc_run;

    t_rate_update rate_q[$];

    function automatic logic [31:0] raise_rate(input longint unsigned inc, ref logic clamp);
        longint unsigned s;
        s = longint'(cur_rate) + inc;
        if (s > 64'hFFFF_FFFF) begin
            clamp = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic [31:0] shrink_rate(input longint unsigned d);
        longint unsigned r;
        r = longint'(cur_rate);
        return 32'(r - ((r * d) >> 16));
    endfunction

    function automatic t_rate_update update_rate(input logic [31:0] rtt);
        longint unsigned a, beta, mr, w, lo, d, g;
        longint hi, diff, nv;
        logic [31:0] prev;
        t_rate_update u;
        logic clamp;
        prev = last_rtt;
        a    = alpha_q > 65536 ? 65536 : alpha_q;
        beta = beta_q > 65536 ? 65536 : beta_q;
        mr   = base_rtt == 0 ? 1 : base_rtt;
        clamp = 1'b0;
        u.region = REG_NONE;
        last_rtt = rtt;

        diff = longint'(rtt) - longint'(prev);
        w    = 65536 - a;
        lo   = longint'(diff_avg) & 64'hFFFF;
        hi   = (diff_avg - longint'(lo)) >>> 16;
        nv   = hi * longint'(w) + longint'((lo * w) >> 16) + longint'(a) * diff;
        if (nv > AvgMax) nv = AvgMax;
        if (nv < AvgMin) nv = AvgMin;
        diff_avg = nv;

        if (prev != 0) begin
            if (longint'(rtt) < thr_low) begin
                u.region = REG_LOW;
                cur_rate = raise_rate(add_step, clamp);
            end else if (longint'(rtt) > thr_high) begin
                d = (beta * (longint'(rtt) - thr_high)) / longint'(rtt);
                u.region = REG_HIGH;
                cur_rate = shrink_rate(d);
            end else if (diff_avg <= 0) begin
                if (inc_run >= 5) begin
                    u.region = REG_HYPER;
                    cur_rate = raise_rate(add_step * 5, clamp);
                end else begin
                    u.region = REG_ADD;
                    cur_rate = raise_rate(add_step, clamp);
                    inc_run++;
                end
            end else begin
                g = longint'(diff_avg) / mr;
                if (g > 64'h1_0000_0000) g = 64'h1_0000_0000;
                d = (beta * g) >> 16;
                u.region = REG_GDEC;
                if (d > 65536) begin
                    cur_rate = '0;
                    clamp = 1'b1;
                end else begin
                    cur_rate = shrink_rate(d);
                end
                inc_run = 1;
            end
        end
        u.rate    = cur_rate;
        u.clamped = clamp;
        return u;
    endfunction

    always @(posedge i_clk) begin
        t_rate_update exp_u;
        if (!i_rst_n) begin
            base_rtt = 10000; thr_low = 50000; thr_high = 500000;
            add_step = 10000; alpha_q = 57344; beta_q = 52429;
            last_rtt = '0; diff_avg = 0; cur_rate = 32'd100000000; inc_run = 0;
            rate_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_INITIAL_RATE: cur_rate = i_cfg_data;
                    CFG_MIN_RTT:     base_rtt = i_cfg_data;
                    CFG_T_LOW:       thr_low = i_cfg_data;
                    CFG_T_HIGH:      thr_high = i_cfg_data;
                    CFG_RATE_STEP:   add_step = i_cfg_data;
                    CFG_EWMA_WEIGHT: alpha_q = i_cfg_data[16:0];
                    CFG_DECREASE:    beta_q = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (rate_q.size() == 0) begin
                    $display("%0t: result item with nothing expected, got %h", $time, i_m_tdata);
                    o_errors++;
                end else begin
                    exp_u = rate_q.pop_front();
                    if (i_m_tdata[31:0] !== exp_u.rate || i_m_tdata[34:32] !== exp_u.region
                        || i_m_tdata[35] !== exp_u.clamped) begin
                        $display({"%0t: mismatch expected rate %0d region %0d clamped %0b,",
                                  " got rate %0d region %0d clamped %0b"},
                                 $time, exp_u.rate, exp_u.region, exp_u.clamped,
                                 i_m_tdata[31:0], i_m_tdata[34:32], i_m_tdata[35]);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                rate_q.push_back(update_rate(i_s_tdata));
        end
        o_pending = rate_q.size();
    end

endmodule

`default_nettype wire

// File: dv/tb_rtt_gradient_rate_controller_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtt_gradient_rate_controller_unit
// Drives rtt items through the rate controller over several register settings
// (defaults, extremes, overlapping thresholds) with random idling on both
// sides in most runs; the scoreboard predicts and checks every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rtt_gradient_rate_controller_unit;
    import rgrc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          errors, pending;

    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          hold_req = 0;  // bumped by the stimulus
    int          hold_ack = 0;  // caught up by the result side
    logic [31:0] cur_low = 32'd50000, cur_high = 32'd500000, walk_rtt = 32'd100000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rtt_gradient_rate_controller_unit i_dut (
        .i_clk, .i_rst_n,
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
    );

    rgrc_scoreboard i_scoreboard (
        .i_clk, .i_rst_n,
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // result side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            m_tready <= 1'b0;
            repeat (400) @(posedge i_clk);
            hold_ack = hold_req;
        end else begin
            m_tready <= !(sink_idle_en && $urandom_range(99) < 28);
        end
    end

    task automatic send_rtt(input logic [31:0] rtt);
        if (src_idle_en && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 28) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rtt;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        if (idx == CFG_T_LOW) cur_low = value;
        if (idx == CFG_T_HIGH) cur_high = value;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // mostly a random walk between the thresholds, with outliers and restarts
    function automatic logic [31:0] pick_rtt;
        int unsigned sel;
        logic [31:0] lo_b, hi_b;
        sel  = $urandom_range(99);
        lo_b = cur_low < cur_high ? cur_low : cur_high;
        hi_b = cur_low < cur_high ? cur_high : cur_low;
        if (sel < 4) return '0;
        if (sel < 14) return $urandom;
        if (sel < 22 && cur_low != 0) return $urandom_range(cur_low - 1, 0);
        if (sel < 30 && cur_high != 32'hFFFF_FFFF) return $urandom_range(32'hFFFF_FFFF, cur_high + 1);
        if (sel < 65) walk_rtt = walk_rtt - $urandom_range(hi_b / 8 + 1, 0);
        else walk_rtt = walk_rtt + $urandom_range(hi_b / 8 + 1, 0);
        if (walk_rtt < lo_b || walk_rtt > hi_b) walk_rtt = $urandom_range(hi_b, lo_b);
        return walk_rtt;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_rtt(pick_rtt());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first ack, each region, extremes of rtt
        send_rtt(32'd100000);
        send_rtt(32'd100000);
        send_rtt(32'd1000);
        send_rtt(32'hFFFF_FFFF);
        send_rtt(32'd0);
        send_rtt(32'd0);
        send_rtt(32'd60000);
        repeat (8) send_rtt(32'd60000);
        send_rtt(32'd400000);
        send_rtt(32'd300000);
        send_rtt(32'd200000);
        send_rtt(32'd100000);
        send_rtt(32'd60000);
        send_rtt(32'd500000);
        send_rtt(32'd500001);
        send_rtt(32'd50000);
        send_rtt(32'd49999);
        drain();

        // defaults, with a long result stall
        hold_req++;
        run_random(180);
        drain();

        // extremes: max rate and step, weight and factor above one, zero min rtt
        write_reg(CFG_INITIAL_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_RATE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_EWMA_WEIGHT, 32'h0001_FFFF);
        write_reg(CFG_DECREASE, 32'h0001_FFFF);
        write_reg(CFG_MIN_RTT, 32'd0);
        drain();
        run_random(150);
        drain();

        // no idling, weight one, small min rtt
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(CFG_INITIAL_RATE, 32'd1);
        write_reg(CFG_RATE_STEP, 32'd0);
        write_reg(CFG_EWMA_WEIGHT, 32'd65536);
        write_reg(CFG_DECREASE, 32'd65536);
        write_reg(CFG_MIN_RTT, 32'd1);
        write_reg(CFG_T_LOW, 32'd0);
        write_reg(CFG_T_HIGH, 32'hFFFF_FFFF);
        drain();
        run_random(200);
        drain();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;

        // zero weight and factor, overlapping thresholds
        write_reg(CFG_INITIAL_RATE, 32'd5000000);
        write_reg(CFG_RATE_STEP, 32'd1000);
        write_reg(CFG_EWMA_WEIGHT, 32'd0);
        write_reg(CFG_DECREASE, 32'd0);
        write_reg(CFG_MIN_RTT, 32'hFFFF_FFFF);
        write_reg(CFG_T_LOW, 32'd300000);
        write_reg(CFG_T_HIGH, 32'd1);
        drain();
        run_random(150);
        drain();

        // typical tuning, narrow band
        write_reg(CFG_INITIAL_RATE, 32'd40000000);
        write_reg(CFG_RATE_STEP, 32'd50000);
        write_reg(CFG_EWMA_WEIGHT, 32'd16384);
        write_reg(CFG_DECREASE, 32'd32768);
        write_reg(CFG_MIN_RTT, 32'd2000);
        write_reg(CFG_T_LOW, 32'd20000);
        write_reg(CFG_T_HIGH, 32'd80000);
        drain();
        hold_req++;
        run_random(250);
        drain();

        // random settings
        repeat (3) begin
            write_reg(CFG_INITIAL_RATE, $urandom);
            write_reg(CFG_RATE_STEP, $urandom_range(1000000, 0));
            write_reg(CFG_EWMA_WEIGHT, $urandom_range(65536, 0));
            write_reg(CFG_DECREASE, $urandom_range(65536, 0));
            write_reg(CFG_MIN_RTT, $urandom_range(100000, 1));
            write_reg(CFG_T_LOW, $urandom_range(100000, 0));
            write_reg(CFG_T_HIGH, $urandom_range(2000000, 100000));
            drain();
            run_random(120);
            drain();
        end

        if (errors == 0) begin
            $display("tb_rtt_gradient_rate_controller_unit: done, clean");
        end else begin
            $display("tb_rtt_gradient_rate_controller_unit: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_rtt_gradient_rate_controller_unit: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
